/* rtl/spc_pkg.sv */
// spc_pkg: shared types, constants and the cordic angle table for spherical_to_cartesian
// no dependencies
`timescale 1ns / 1ps
package spc_pkg;

   // cordic iteration count, one pipeline stage per iteration
   localparam int CORDIC_STEPS = 24;

   // field widths
   localparam int LAT_W  = 28;
   localparam int LON_W  = 29;
   localparam int ALT_W  = 32;
   localparam int RAD_W  = 32;
   localparam int R_W    = 34;
   localparam int OUT_W  = 34;

   // internal widths: angle residue, cordic vector, clamped q2.30 factor (holds +1.0)
   localparam int ANG_W  = 30;
   localparam int CV_W   = 33;
   localparam int FAC_W  = 32;

   // split of r for the final multiply
   localparam int RLO_W  = 17;
   localparam int RHI_W  = R_W - RLO_W;
   localparam int PHI_W  = RHI_W + FAC_W;
   localparam int PLO_W  = RLO_W + 1 + FAC_W;
   localparam int SUM_W  = 65;

   // angle constants, 20 fraction bits of a degree
   localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(188743680);
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(94371840);
   localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(377487360);

   // q2.30 constants
   localparam logic signed [CV_W-1:0]  CORDIC_GAIN  = CV_W'(652032874);
   localparam logic signed [CV_W-1:0]  Q30_ONE_CV   = CV_W'(1073741824);
   localparam logic signed [63:0]      Q30_HALF     = 64'sd536870912;
   localparam logic signed [63:0]      Q30_ONE      = 64'sd1073741824;

   // end-to-end latency from accepted start to result strobe
   localparam int LATENCY = CORDIC_STEPS + 7;

   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic signed [CV_W-1:0]  cvec_type;
   typedef logic signed [FAC_W-1:0] fac_type;
   typedef logic signed [R_W-1:0]   rad_type;

   // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest
   function automatic ang_type atan_deg(input int idx);
      ang_type v;
      case (idx)
         0:       v = ANG_W'(47185920);
         1:       v = ANG_W'(27855475);
         2:       v = ANG_W'(14718068);
         3:       v = ANG_W'(7471121);
         4:       v = ANG_W'(3750058);
         5:       v = ANG_W'(1876857);
         6:       v = ANG_W'(938658);
         7:       v = ANG_W'(469357);
         8:       v = ANG_W'(234682);
         9:       v = ANG_W'(117342);
         10:      v = ANG_W'(58671);
         11:      v = ANG_W'(29335);
         12:      v = ANG_W'(14668);
         13:      v = ANG_W'(7334);
         14:      v = ANG_W'(3667);
         15:      v = ANG_W'(1833);
         16:      v = ANG_W'(917);
         17:      v = ANG_W'(458);
         18:      v = ANG_W'(229);
         19:      v = ANG_W'(115);
         20:      v = ANG_W'(57);
         21:      v = ANG_W'(29);
         22:      v = ANG_W'(14);
         23:      v = ANG_W'(7);
         24:      v = ANG_W'(4);
         25:      v = ANG_W'(2);
         26:      v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/spherical_to_cartesian.sv */
// spherical_to_cartesian: latitude/longitude/altitude to x, y, z in q18.16
// depends on spc_pkg
`timescale 1ns / 1ps
// Fully pipelined converter: one point can be started every clock cycle and busy
// never rises. Each result appears on the rsp_ ports, marked by rsp_strobe, for
// one cycle only; the receiver must take it then, since the block cannot hold it.
// The pipeline is the cordic chain (one register stage per iteration, lat and lon
// in parallel) plus input, fold, clamp, factor product, factor rounding and two
// split multiply stages.
// The sphere radius is written through csr_write_enable/csr_write_data; the user
// must do this only while idle, the block itself does not enforce it.
module spherical_to_cartesian (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [spc_pkg::LAT_W-1:0]    req_latitude_deg,
   input  logic signed [spc_pkg::LON_W-1:0]    req_longitude_deg,
   input  logic signed [spc_pkg::ALT_W-1:0]    req_altitude,
   input  logic                                csr_write_enable,
   input  logic        [spc_pkg::RAD_W-1:0]    csr_write_data,
   output logic                                rsp_strobe,
   output logic signed [spc_pkg::OUT_W-1:0]    rsp_x_coord,
   output logic signed [spc_pkg::OUT_W-1:0]    rsp_y_coord,
   output logic signed [spc_pkg::OUT_W-1:0]    rsp_z_coord
);

   localparam int N = spc_pkg::CORDIC_STEPS;

   // radius register
   logic [spc_pkg::RAD_W-1:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= spc_pkg::RAD_W'(65536);
      end else if (csr_write_enable) begin
         radius_ff <= csr_write_data;
      end
   end

   assign busy = 1'b0;

   // input stage: capture angles, form r
   logic                    v_in_ff;
   spc_pkg::ang_type        lat_raw_ff, lon_raw_ff;
   spc_pkg::rad_type        r_in_ff;
   always_ff @(posedge clock) begin
      if (reset) v_in_ff <= 1'b0;
      else       v_in_ff <= start;
   end
   always_ff @(posedge clock) begin
      lat_raw_ff <= spc_pkg::ANG_W'(req_latitude_deg);
      lon_raw_ff <= spc_pkg::ANG_W'(req_longitude_deg);
      r_in_ff    <= spc_pkg::R_W'(signed'({1'b0, radius_ff}))
                  + spc_pkg::R_W'(req_altitude);
   end

   // fold: wrap longitude once, then fold both into [-90, 90]
   spc_pkg::ang_type lon_wrap;
   spc_pkg::ang_type lat_fold_in, lon_fold_in;
   logic             lat_neg_in, lon_neg_in;
   always_comb begin
      if (lon_raw_ff >= spc_pkg::HALF_TURN)       lon_wrap = lon_raw_ff - spc_pkg::FULL_TURN;
      else if (lon_raw_ff < -spc_pkg::HALF_TURN)  lon_wrap = lon_raw_ff + spc_pkg::FULL_TURN;
      else                                        lon_wrap = lon_raw_ff;
      lat_neg_in  = 1'b1;
      lon_neg_in  = 1'b1;
      if (lat_raw_ff > spc_pkg::QUARTER_TURN)       lat_fold_in = spc_pkg::HALF_TURN - lat_raw_ff;
      else if (lat_raw_ff < -spc_pkg::QUARTER_TURN) lat_fold_in = -spc_pkg::HALF_TURN - lat_raw_ff;
      else begin
         lat_fold_in = lat_raw_ff;
         lat_neg_in  = 1'b0;
      end
      if (lon_wrap > spc_pkg::QUARTER_TURN)         lon_fold_in = spc_pkg::HALF_TURN - lon_wrap;
      else if (lon_wrap < -spc_pkg::QUARTER_TURN)   lon_fold_in = -spc_pkg::HALF_TURN - lon_wrap;
      else begin
         lon_fold_in = lon_wrap;
         lon_neg_in  = 1'b0;
      end
   end

   // cordic pipeline, lane 0 latitude, lane 1 longitude; index 0 is the fold stage
   logic                v_ff   [N+1];
   spc_pkg::cvec_type   cx_ff  [N+1][2];
   spc_pkg::cvec_type   cy_ff  [N+1][2];
   spc_pkg::ang_type    cz_ff  [N+1][2];
   logic                neg_ff [N+1][2];
   spc_pkg::rad_type    r_ff   [N+1];

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else       v_ff[0] <= v_in_ff;
   end
   always_ff @(posedge clock) begin
      cx_ff[0][0]  <= spc_pkg::CORDIC_GAIN;
      cx_ff[0][1]  <= spc_pkg::CORDIC_GAIN;
      cy_ff[0][0]  <= '0;
      cy_ff[0][1]  <= '0;
      cz_ff[0][0]  <= lat_fold_in;
      cz_ff[0][1]  <= lon_fold_in;
      neg_ff[0][0] <= lat_neg_in;
      neg_ff[0][1] <= lon_neg_in;
      r_ff[0]      <= r_in_ff;
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else       v_ff[k+1] <= v_ff[k];
      end
      always_ff @(posedge clock) begin
         r_ff[k+1] <= r_ff[k];
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         spc_pkg::cvec_type dx, dy;
         assign dx = cy_ff[k][l] >>> k;
         assign dy = cx_ff[k][l] >>> k;
         // rotate toward zero residual angle
         always_ff @(posedge clock) begin
            neg_ff[k+1][l] <= neg_ff[k][l];
            if (cz_ff[k][l] >= 0) begin
               cx_ff[k+1][l] <= cx_ff[k][l] - dx;
               cy_ff[k+1][l] <= cy_ff[k][l] + dy;
               cz_ff[k+1][l] <= cz_ff[k][l] - spc_pkg::atan_deg(k);
            end else begin
               cx_ff[k+1][l] <= cx_ff[k][l] + dx;
               cy_ff[k+1][l] <= cy_ff[k][l] - dy;
               cz_ff[k+1][l] <= cz_ff[k][l] + spc_pkg::atan_deg(k);
            end
         end
      end
   end

   // clamp sine/cosine to [-1, 1] and apply the fold sign to the cosines
   function automatic spc_pkg::fac_type clamp_cv(input spc_pkg::cvec_type v);
      spc_pkg::fac_type o;
      if (v > spc_pkg::Q30_ONE_CV)       o = spc_pkg::FAC_W'(spc_pkg::Q30_ONE_CV);
      else if (v < -spc_pkg::Q30_ONE_CV) o = spc_pkg::FAC_W'(-spc_pkg::Q30_ONE_CV);
      else                               o = spc_pkg::FAC_W'(v);
      return o;
   endfunction

   // round q60 product back to q2.30 and clamp
   function automatic spc_pkg::fac_type round_q30(input logic signed [63:0] p);
      logic signed [63:0] s;
      spc_pkg::fac_type   o;
      s = (p + spc_pkg::Q30_HALF) >>> 30;
      if (s > spc_pkg::Q30_ONE)       o = spc_pkg::FAC_W'(spc_pkg::Q30_ONE);
      else if (s < -spc_pkg::Q30_ONE) o = spc_pkg::FAC_W'(-spc_pkg::Q30_ONE);
      else                            o = spc_pkg::FAC_W'(s);
      return o;
   endfunction

   logic             vc_ff;
   spc_pkg::fac_type slat_c_ff, clat_c_ff, slon_c_ff, clon_c_ff;
   spc_pkg::rad_type rc_ff;
   spc_pkg::fac_type clat_c_in, clon_c_in;
   assign clat_c_in = clamp_cv(cx_ff[N][0]);
   assign clon_c_in = clamp_cv(cx_ff[N][1]);
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else       vc_ff <= v_ff[N];
   end
   always_ff @(posedge clock) begin
      slat_c_ff <= clamp_cv(cy_ff[N][0]);
      slon_c_ff <= clamp_cv(cy_ff[N][1]);
      clat_c_ff <= neg_ff[N][0] ? -clat_c_in : clat_c_in;
      clon_c_ff <= neg_ff[N][1] ? -clon_c_in : clon_c_in;
      rc_ff     <= r_ff[N];
   end

   // factor products sin(lon)*cos(lat) and cos(lon)*cos(lat)
   logic                     vp_ff;
   logic signed [63:0]       px_ff, pz_ff;
   spc_pkg::fac_type         slat_p_ff;
   spc_pkg::rad_type         rp_ff;
   always_ff @(posedge clock) begin
      if (reset) vp_ff <= 1'b0;
      else       vp_ff <= vc_ff;
   end
   always_ff @(posedge clock) begin
      px_ff     <= 64'(slon_c_ff * clat_c_ff);
      pz_ff     <= 64'(clon_c_ff * clat_c_ff);
      slat_p_ff <= slat_c_ff;
      rp_ff     <= rc_ff;
   end

   // round factors
   logic             vf_ff;
   spc_pkg::fac_type fx_ff, fy_ff, fz_ff;
   spc_pkg::rad_type rf_ff;
   always_ff @(posedge clock) begin
      if (reset) vf_ff <= 1'b0;
      else       vf_ff <= vp_ff;
   end
   always_ff @(posedge clock) begin
      fx_ff <= round_q30(px_ff);
      fz_ff <= round_q30(pz_ff);
      fy_ff <= slat_p_ff;
      rf_ff <= rp_ff;
   end

   // r times factor as two partial products on the split radius
   logic signed [spc_pkg::RHI_W-1:0] r_hi;
   logic signed [spc_pkg::RLO_W:0]   r_lo;
   assign r_hi = rf_ff[spc_pkg::R_W-1:spc_pkg::RLO_W];
   assign r_lo = signed'({1'b0, rf_ff[spc_pkg::RLO_W-1:0]});

   logic                             vm_ff;
   logic signed [spc_pkg::PHI_W-1:0] hx_ff, hy_ff, hz_ff;
   logic signed [spc_pkg::PLO_W-1:0] lx_ff, ly_ff, lz_ff;
   always_ff @(posedge clock) begin
      if (reset) vm_ff <= 1'b0;
      else       vm_ff <= vf_ff;
   end
   always_ff @(posedge clock) begin
      hx_ff <= spc_pkg::PHI_W'(r_hi * fx_ff);
      hy_ff <= spc_pkg::PHI_W'(r_hi * fy_ff);
      hz_ff <= spc_pkg::PHI_W'(r_hi * fz_ff);
      lx_ff <= spc_pkg::PLO_W'(r_lo * fx_ff);
      ly_ff <= spc_pkg::PLO_W'(r_lo * fy_ff);
      lz_ff <= spc_pkg::PLO_W'(r_lo * fz_ff);
   end

   // combine partials, round to q18.16, saturate
   function automatic logic signed [spc_pkg::OUT_W-1:0] finish(
      input logic signed [spc_pkg::PHI_W-1:0] h,
      input logic signed [spc_pkg::PLO_W-1:0] l
   );
      logic signed [spc_pkg::SUM_W-1:0] s;
      logic signed [spc_pkg::SUM_W-1:0] q;
      logic signed [spc_pkg::OUT_W-1:0] o;
      s = (spc_pkg::SUM_W'(h) <<< spc_pkg::RLO_W) + spc_pkg::SUM_W'(l)
        + spc_pkg::SUM_W'(spc_pkg::Q30_HALF);
      q = s >>> 30;
      if (q > spc_pkg::SUM_W'(64'sd8589934591))
         o = {1'b0, {(spc_pkg::OUT_W-1){1'b1}}};
      else if (q < -spc_pkg::SUM_W'(64'sd8589934592))
         o = {1'b1, {(spc_pkg::OUT_W-1){1'b0}}};
      else
         o = spc_pkg::OUT_W'(q);
      return o;
   endfunction

   logic                             strobe_ff;
   logic signed [spc_pkg::OUT_W-1:0] x_ff, y_ff, z_ff;
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else       strobe_ff <= vm_ff;
   end
   always_ff @(posedge clock) begin
      x_ff <= finish(hx_ff, lx_ff);
      y_ff <= finish(hy_ff, ly_ff);
      z_ff <= finish(hz_ff, lz_ff);
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_x_coord = x_ff;
   assign rsp_y_coord = y_ff;
   assign rsp_z_coord = z_ff;

`ifndef NO_ASSERTIONS
   // every accepted beat comes out after the fixed latency
   a_latency_out : assert property (@(posedge clock) disable iff (reset)
      start |-> ##(spc_pkg::LATENCY) rsp_strobe)
      else $error("result beat missing after start");

   // no result beat without a start beat the latency earlier
   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !reset, spc_pkg::LATENCY))
      else $error("result beat without matching start");

   // cordic chain valid follows the fold stage valid into the first cordic register
   a_chain : assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |=> v_ff[1])
      else $error("cordic valid lost");
`endif

endmodule
